// File: src/cvp_pkg.sv
// Shared constants and types for the camera view/projection block.
// Used by cvp_sincos, cvp_aspect_div and camera_view_projection_matrix.
// Depends on nothing.
package cvp_pkg;

    localparam int ANGLE_W      = 16;
    localparam int COORD_W      = 32;
    localparam int A_W          = 35;
    localparam int SC_W         = 18;
    localparam int CORDIC_STEPS = 30;
    localparam int SC_LAT       = CORDIC_STEPS + 4;
    localparam int DIV_STEPS    = 34;
    localparam int VP_W         = 15;

    localparam logic signed [A_W-1:0] Q29_PI      = 35'sd1686629713;
    localparam logic signed [A_W-1:0] Q29_HALF_PI = 35'sd843314856;
    localparam logic signed [A_W-1:0] Q29_TWO_PI  = 35'sd3373259426;
    localparam logic signed [31:0]    CORDIC_K    = 32'sd326016437;

    localparam logic signed [31:0] ATAN_Q29 [CORDIC_STEPS] = '{
        32'sd421657428, 32'sd248918915, 32'sd131521918, 32'sd66762579,
        32'sd33510843, 32'sd16771758, 32'sd8387925, 32'sd4194219,
        32'sd2097141, 32'sd1048575, 32'sd524288, 32'sd262144, 32'sd131072,
        32'sd65536, 32'sd32768, 32'sd16384, 32'sd8192, 32'sd4096, 32'sd2048,
        32'sd1024, 32'sd512, 32'sd256, 32'sd128, 32'sd64, 32'sd32, 32'sd16,
        32'sd8, 32'sd4, 32'sd2, 32'sd1
    };

    localparam logic [33:0] COT_Q32 = 34'd10368968296;

    // Status of the aspect-ratio divider as seen by the top level.
    typedef struct packed {
        logic                 busy;
        logic [DIV_STEPS-1:0] quot;
    } div_status_t;

endpackage

// File: src/cvp_sincos.sv
// Pipelined sine and cosine of one Q4.12 angle: range reduction, a 30-stage
// rotation CORDIC and rounding to Q2.16, advancing only while en is high.
// Depends on cvp_pkg.
module cvp_sincos import cvp_pkg::*; (
    input  logic                   aclk,
    input  logic                   en,
    input  logic signed [ANGLE_W-1:0] angle,
    output logic signed [SC_W-1:0] sin_q16,
    output logic signed [SC_W-1:0] cos_q16
);

    logic signed [A_W-1:0] a0;
    logic signed [A_W-1:0] r1_reg;
    logic signed [A_W-1:0] r2_reg;
    logic signed [A_W-1:0] r1_next;
    logic signed [A_W-1:0] r2_next;
    logic signed [A_W-1:0] z0_next;
    logic                  flip_next;

    logic signed [31:0] x_reg [CORDIC_STEPS+1];
    logic signed [31:0] y_reg [CORDIC_STEPS+1];
    logic signed [31:0] z_reg [CORDIC_STEPS+1];
    logic               flip_reg [CORDIC_STEPS+1];

    logic signed [31:0] xr;
    logic signed [31:0] yr;
    logic signed [SC_W-1:0] sin_reg;
    logic signed [SC_W-1:0] cos_reg;

    // Angle to Q29 radians.
    assign a0 = {{(A_W-ANGLE_W-17){angle[ANGLE_W-1]}}, angle, 17'b0};

    // Remainder by two pi, truncating toward zero: one correction is enough.
    always_comb begin
        if (a0 >= Q29_TWO_PI) begin
            r1_next = a0 - Q29_TWO_PI;
        end else if (a0 <= -Q29_TWO_PI) begin
            r1_next = a0 + Q29_TWO_PI;
        end else begin
            r1_next = a0;
        end
    end

    always_comb begin
        if (r1_reg > Q29_PI) begin
            r2_next = r1_reg - Q29_TWO_PI;
        end else if (r1_reg < -Q29_PI) begin
            r2_next = r1_reg + Q29_TWO_PI;
        end else begin
            r2_next = r1_reg;
        end
    end

    // Fold into the right half plane; the cosine changes sign there.
    always_comb begin
        if (r2_reg > Q29_HALF_PI) begin
            z0_next   = Q29_PI - r2_reg;
            flip_next = 1'b1;
        end else if (r2_reg < -Q29_HALF_PI) begin
            z0_next   = -Q29_PI - r2_reg;
            flip_next = 1'b1;
        end else begin
            z0_next   = r2_reg;
            flip_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            r1_reg      <= r1_next;
            r2_reg      <= r2_next;
            x_reg[0]    <= CORDIC_K;
            y_reg[0]    <= '0;
            z_reg[0]    <= z0_next[31:0];
            flip_reg[0] <= flip_next;
        end
    end

    for (genvar i = 0; i < CORDIC_STEPS; i++) begin : g_step
        always_ff @(posedge aclk) begin
            if (en) begin
                flip_reg[i+1] <= flip_reg[i];
                if (z_reg[i] >= 0) begin
                    x_reg[i+1] <= x_reg[i] - (y_reg[i] >>> i);
                    y_reg[i+1] <= y_reg[i] + (x_reg[i] >>> i);
                    z_reg[i+1] <= z_reg[i] - ATAN_Q29[i];
                end else begin
                    x_reg[i+1] <= x_reg[i] + (y_reg[i] >>> i);
                    y_reg[i+1] <= y_reg[i] - (x_reg[i] >>> i);
                    z_reg[i+1] <= z_reg[i] + ATAN_Q29[i];
                end
            end
        end
    end

    assign xr = (x_reg[CORDIC_STEPS] + 32'sd4096) >>> 13;
    assign yr = (y_reg[CORDIC_STEPS] + 32'sd4096) >>> 13;

    always_ff @(posedge aclk) begin
        if (en) begin
            sin_reg <= yr[SC_W-1:0];
            cos_reg <= flip_reg[CORDIC_STEPS] ? -xr[SC_W-1:0] : xr[SC_W-1:0];
        end
    end

    assign sin_q16 = sin_reg;
    assign cos_q16 = cos_reg;

endmodule

// File: src/cvp_aspect_div.sv
// Restoring divider for the projection's x scale, cot(fov/2)*height/width,
// one quotient bit per cycle. Restarted whenever the viewport changes.
// Depends on cvp_pkg.
module cvp_aspect_div import cvp_pkg::*; (
    input  logic            aclk,
    input  logic            aresetn,
    input  logic            start,
    input  logic [VP_W-1:0] width,
    input  logic [VP_W-1:0] height,
    output div_status_t     status
);

    logic [VP_W-1:0]      wd;
    logic [VP_W-1:0]      ht;
    logic [49:0]          num;
    logic                 busy_reg;
    logic [5:0]           cnt_reg;
    logic [DIV_STEPS-1:0] n_reg;
    logic [VP_W-1:0]      rem_reg;
    logic [VP_W-1:0]      d_reg;
    logic [DIV_STEPS-1:0] q_reg;
    logic [VP_W:0]        trial;
    logic                 take;
    logic [VP_W-1:0]      rem_next;

    // A zero register acts as one.
    assign wd  = (width  == '0) ? VP_W'(1) : width;
    assign ht  = (height == '0) ? VP_W'(1) : height;

    // Rounded quotient: floor((cot*ht + wd*2^15) / (wd*2^16)); the 2^16 is
    // taken off the numerator first, which leaves the floor unchanged.
    assign num = 50'(COT_Q32 * ht) + 50'({wd, 15'b0});

    assign trial    = {rem_reg, n_reg[DIV_STEPS-1]};
    assign take     = trial >= {1'b0, d_reg};
    assign rem_next = take ? VP_W'(trial - {1'b0, d_reg}) : trial[VP_W-1:0];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            cnt_reg  <= '0;
        end else if (start) begin
            busy_reg <= 1'b1;
            cnt_reg  <= 6'(DIV_STEPS);
        end else if (busy_reg) begin
            cnt_reg <= cnt_reg - 6'd1;
            if (cnt_reg == 6'd1) begin
                busy_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (start) begin
            n_reg   <= num[49:16];
            rem_reg <= '0;
            d_reg   <= wd;
            q_reg   <= '0;
        end else if (busy_reg) begin
            n_reg   <= {n_reg[DIV_STEPS-2:0], 1'b0};
            rem_reg <= rem_next;
            q_reg   <= {q_reg[DIV_STEPS-2:0], take};
        end
    end

    assign status.busy = busy_reg;
    assign status.quot = q_reg;

endmodule

// File: src/camera_view_projection_matrix.sv
// Camera view and projection matrix generator, top level.
// Depends on cvp_pkg, cvp_sincos and cvp_aspect_div.
//
// Usage: a transaction on the s_ channel carries pitch, yaw and roll (Q4.12
// radians) and the camera position (Q16.16). For each one the block sends
// nine transactions on the m_ channel, one matrix column each: the four view
// columns, the four projection columns, then the forward vector, with m_tlast
// on the ninth. The viewport width and height are written through the cfg_
// port while the block is idle; a width or height of zero acts as one.
// The first column of an item reaches the m_ channel through the input
// register, a 34-stage sine/cosine pipeline with range reduction, two product
// stages, two translation stages and the serializer load. While the receiver
// is ready, the output column serializer sends one column per cycle; the
// pipeline keeps taking new items while a finished item is being sent.
// Reset and every configuration write start the aspect-ratio divider, which
// holds s_tready low until it has finished. When the receiver stalls, the
// serializer holds its column and the whole pipeline freezes once its last
// stage is full; nothing is dropped or repeated.
module camera_view_projection_matrix import cvp_pkg::*; (
    input  logic           aclk,
    input  logic           aresetn,
    input  logic           s_tvalid,
    output logic           s_tready,
    // pitch_angle, yaw_angle, roll_angle, pos_x, pos_y, pos_z
    input  logic [143:0]   s_tdata,
    output logic           m_tvalid,
    input  logic           m_tready,
    // elem0, elem1, elem2, elem3
    output logic [127:0]   m_tdata,
    // matrix_id, column_index
    output logic [3:0]     m_tuser,
    output logic           m_tlast,
    input  logic           cfg_wr_en,
    input  logic           cfg_index,
    input  logic [VP_W-1:0] cfg_wr_data
);

    localparam logic [1:0] MAT_VIEW = 2'd0;
    localparam logic [1:0] MAT_PROJ = 2'd1;
    localparam logic [1:0] MAT_FWD  = 2'd2;
    localparam logic       REG_VIEWPORT_WIDTH  = 1'b0;
    localparam logic       REG_VIEWPORT_HEIGHT = 1'b1;
    localparam logic [3:0] LAST_BEAT = 4'd8;
    localparam int         U_W = SC_W + 1;

    localparam logic signed [COORD_W-1:0] ONE_Q16 = 32'sd65536;
    localparam logic signed [COORD_W-1:0] COT_Q16 = 32'sd158218;
    localparam logic signed [COORD_W-1:0] P22_Q16 = 32'sd65602;
    localparam logic signed [COORD_W-1:0] P32_Q16 = -32'sd6560;
    localparam logic signed [COORD_W-1:0] SAT_MAX = 32'sh7FFFFFFF;

    typedef struct packed {
        logic signed [COORD_W-1:0] z;
        logic signed [COORD_W-1:0] y;
        logic signed [COORD_W-1:0] x;
    } pos_t;

    function automatic logic signed [SC_W-1:0] mulq(input logic signed [SC_W-1:0] a,
                                                    input logic signed [SC_W-1:0] b);
        logic signed [2*SC_W-1:0] p;
        p = a * b + 36'sd32768;
        return SC_W'(p >>> 16);
    endfunction

    // Exact product of a Q3.16 factor and a position, rounded half up.
    function automatic logic signed [36:0] mulpos(input logic signed [U_W-1:0] u,
                                                  input logic signed [COORD_W-1:0] p);
        logic signed [34:0] hi;
        logic signed [35:0] lo;
        hi = u * $signed(p[31:16]);
        lo = (u * $signed({1'b0, p[15:0]}) + 36'sd32768) >>> 16;
        return 37'(hi) + 37'(lo);
    endfunction

    function automatic logic signed [COORD_W-1:0] negdot(input logic signed [36:0] a,
                                                         input logic signed [36:0] b,
                                                         input logic signed [36:0] c);
        logic signed [38:0] s;
        s = -(39'(a) + 39'(b) + 39'(c));
        if (s > 39'sd2147483647) begin
            return 32'sh7FFFFFFF;
        end else if (s < -39'sd2147483648) begin
            return 32'sh80000000;
        end
        return s[COORD_W-1:0];
    endfunction

    // Configuration and divider control.
    logic [VP_W-1:0] vp_width_reg;
    logic [VP_W-1:0] vp_height_reg;
    logic            dirty_reg;
    div_status_t     div_st;

    // Pipeline control.
    logic adv;
    logic ser_free;
    logic in_accept;

    // Input stage.
    logic                      in_v_reg;
    logic signed [ANGLE_W-1:0] pitch_reg;
    logic signed [ANGLE_W-1:0] yaw_reg;
    logic signed [ANGLE_W-1:0] roll_reg;
    pos_t                      in_pos_reg;

    // Delay line beside the sine/cosine pipeline.
    logic [SC_LAT-1:0] vd_reg;
    pos_t              pd_reg [SC_LAT];

    logic signed [SC_W-1:0] s1, c1, s2, c2, s3, c3;

    // First product stage.
    logic                   m1_v_reg;
    pos_t                   m1_pos_reg;
    logic signed [SC_W-1:0] m1_s2_reg, m1_s3_reg;
    logic signed [SC_W-1:0] c1c3_reg, s1s2_reg, c2s3_reg, c1s2_reg, c3s1_reg;
    logic signed [SC_W-1:0] c2c3_reg, s1s3_reg, c2s1_reg, c1c2_reg, c1s3_reg;

    // Basis stage.
    logic                   m2_v_reg;
    pos_t                   m2_pos_reg;
    logic signed [SC_W-1:0] m2_s2_reg;
    logic signed [U_W-1:0]  u_reg [3];
    logic signed [U_W-1:0]  v_reg [3];
    logic signed [U_W-1:0]  w_reg [3];

    // Translation stages.
    logic                   t1_v_reg;
    logic signed [SC_W-1:0] t1_s2_reg;
    logic signed [U_W-1:0]  t1_u_reg [3];
    logic signed [U_W-1:0]  t1_v_row_reg [3];
    logic signed [U_W-1:0]  t1_w_reg [3];
    logic signed [36:0]     tu_reg [3];
    logic signed [36:0]     tv_reg [3];
    logic signed [36:0]     tw_reg [3];

    logic                      t2_v_reg;
    logic signed [SC_W-1:0]    t2_s2_reg;
    logic signed [U_W-1:0]     t2_u_reg [3];
    logic signed [U_W-1:0]     t2_v_row_reg [3];
    logic signed [U_W-1:0]     t2_w_reg [3];
    logic signed [COORD_W-1:0] tx_reg, ty_reg, tz_reg;

    // Output column serializer.
    logic                      ser_busy_reg;
    logic [3:0]                beat_reg;
    logic signed [SC_W-1:0]    o_s2_reg;
    logic signed [U_W-1:0]     o_u_reg [3];
    logic signed [U_W-1:0]     o_v_reg [3];
    logic signed [U_W-1:0]     o_w_reg [3];
    logic signed [COORD_W-1:0] o_tx_reg, o_ty_reg, o_tz_reg;
    logic signed [COORD_W-1:0] p00_reg;
    logic signed [COORD_W-1:0] p00_sat;

    logic [1:0]                mat_id;
    logic [1:0]                col_idx;
    logic signed [COORD_W-1:0] e0, e1, e2, e3;
    logic                      out_take;

    // ------------------------------------------------------------------
    // Configuration registers and divider restart.
    // ------------------------------------------------------------------
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vp_width_reg  <= 15'd1280;
            vp_height_reg <= 15'd720;
            dirty_reg     <= 1'b1;
        end else begin
            dirty_reg <= cfg_wr_en;
            if (cfg_wr_en) begin
                unique case (cfg_index)
                    REG_VIEWPORT_WIDTH:  vp_width_reg  <= cfg_wr_data;
                    REG_VIEWPORT_HEIGHT: vp_height_reg <= cfg_wr_data;
                    default: ;
                endcase
            end
        end
    end

    cvp_aspect_div u_div (
        .aclk    (aclk),
        .aresetn (aresetn),
        .start   (dirty_reg),
        .width   (vp_width_reg),
        .height  (vp_height_reg),
        .status  (div_st)
    );

    assign p00_sat = (div_st.quot > DIV_STEPS'(SAT_MAX)) ? SAT_MAX
                                                         : div_st.quot[COORD_W-1:0];

    always_ff @(posedge aclk) begin
        p00_reg <= p00_sat;
    end

    // ------------------------------------------------------------------
    // Pipeline advance: every stage moves together unless the last stage
    // holds an item the serializer cannot yet take.
    // ------------------------------------------------------------------
    assign out_take  = m_tvalid && m_tready;
    assign ser_free  = !ser_busy_reg || (out_take && beat_reg == LAST_BEAT);
    assign adv       = !t2_v_reg || ser_free;
    assign s_tready  = adv && !dirty_reg && !div_st.busy;
    assign in_accept = s_tvalid && s_tready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_v_reg <= 1'b0;
            vd_reg   <= '0;
            m1_v_reg <= 1'b0;
            m2_v_reg <= 1'b0;
            t1_v_reg <= 1'b0;
            t2_v_reg <= 1'b0;
        end else if (adv) begin
            in_v_reg <= in_accept;
            vd_reg   <= {vd_reg[SC_LAT-2:0], in_v_reg};
            m1_v_reg <= vd_reg[SC_LAT-1];
            m2_v_reg <= m1_v_reg;
            t1_v_reg <= m2_v_reg;
            t2_v_reg <= t1_v_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            pitch_reg    <= s_tdata[15:0];
            yaw_reg      <= s_tdata[31:16];
            roll_reg     <= s_tdata[47:32];
            in_pos_reg.x <= s_tdata[79:48];
            in_pos_reg.y <= s_tdata[111:80];
            in_pos_reg.z <= s_tdata[143:112];
            pd_reg[0]    <= in_pos_reg;
            for (int i = 1; i < SC_LAT; i++) begin
                pd_reg[i] <= pd_reg[i-1];
            end
        end
    end

    // Pitch is the x rotation (s2, c2), yaw the y rotation (s1, c1) and roll
    // the z rotation (s3, c3).
    cvp_sincos u_sc_pitch (
        .aclk(aclk), .en(adv), .angle(pitch_reg), .sin_q16(s2), .cos_q16(c2)
    );
    cvp_sincos u_sc_yaw (
        .aclk(aclk), .en(adv), .angle(yaw_reg), .sin_q16(s1), .cos_q16(c1)
    );
    cvp_sincos u_sc_roll (
        .aclk(aclk), .en(adv), .angle(roll_reg), .sin_q16(s3), .cos_q16(c3)
    );

    // ------------------------------------------------------------------
    // Pairwise products of the sines and cosines.
    // ------------------------------------------------------------------
    always_ff @(posedge aclk) begin
        if (adv) begin
            m1_pos_reg <= pd_reg[SC_LAT-1];
            m1_s2_reg  <= s2;
            m1_s3_reg  <= s3;
            c1c3_reg   <= mulq(c1, c3);
            s1s2_reg   <= mulq(s1, s2);
            c2s3_reg   <= mulq(c2, s3);
            c1s2_reg   <= mulq(c1, s2);
            c3s1_reg   <= mulq(c3, s1);
            c2c3_reg   <= mulq(c2, c3);
            s1s3_reg   <= mulq(s1, s3);
            c2s1_reg   <= mulq(c2, s1);
            c1c2_reg   <= mulq(c1, c2);
            c1s3_reg   <= mulq(c1, s3);
        end
    end

    // ------------------------------------------------------------------
    // Basis rows u, v, w of the YXZ rotation. Their magnitude stays near one,
    // far inside the output range, so no clamp is needed here.
    // ------------------------------------------------------------------
    always_ff @(posedge aclk) begin
        if (adv) begin
            m2_pos_reg <= m1_pos_reg;
            m2_s2_reg  <= m1_s2_reg;
            u_reg[0]   <= U_W'(c1c3_reg) + U_W'(mulq(s1s2_reg, m1_s3_reg));
            u_reg[1]   <= U_W'(c2s3_reg);
            u_reg[2]   <= U_W'(mulq(c1s2_reg, m1_s3_reg)) - U_W'(c3s1_reg);
            v_reg[0]   <= U_W'(mulq(c3s1_reg, m1_s2_reg)) - U_W'(c1s3_reg);
            v_reg[1]   <= U_W'(c2c3_reg);
            v_reg[2]   <= U_W'(mulq(c1c3_reg, m1_s2_reg)) + U_W'(s1s3_reg);
            w_reg[0]   <= U_W'(c2s1_reg);
            w_reg[1]   <= -U_W'(m1_s2_reg);
            w_reg[2]   <= U_W'(c1c2_reg);
        end
    end

    // ------------------------------------------------------------------
    // Translation: minus the dot product of each row with the position.
    // ------------------------------------------------------------------
    always_ff @(posedge aclk) begin
        if (adv) begin
            t1_s2_reg <= m2_s2_reg;
            for (int i = 0; i < 3; i++) begin
                t1_u_reg[i]     <= u_reg[i];
                t1_v_row_reg[i] <= v_reg[i];
                t1_w_reg[i]     <= w_reg[i];
            end
            tu_reg[0] <= mulpos(u_reg[0], m2_pos_reg.x);
            tu_reg[1] <= mulpos(u_reg[1], m2_pos_reg.y);
            tu_reg[2] <= mulpos(u_reg[2], m2_pos_reg.z);
            tv_reg[0] <= mulpos(v_reg[0], m2_pos_reg.x);
            tv_reg[1] <= mulpos(v_reg[1], m2_pos_reg.y);
            tv_reg[2] <= mulpos(v_reg[2], m2_pos_reg.z);
            tw_reg[0] <= mulpos(w_reg[0], m2_pos_reg.x);
            tw_reg[1] <= mulpos(w_reg[1], m2_pos_reg.y);
            tw_reg[2] <= mulpos(w_reg[2], m2_pos_reg.z);
        end
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            t2_s2_reg <= t1_s2_reg;
            for (int i = 0; i < 3; i++) begin
                t2_u_reg[i]     <= t1_u_reg[i];
                t2_v_row_reg[i] <= t1_v_row_reg[i];
                t2_w_reg[i]     <= t1_w_reg[i];
            end
            tx_reg <= negdot(tu_reg[0], tu_reg[1], tu_reg[2]);
            ty_reg <= negdot(tv_reg[0], tv_reg[1], tv_reg[2]);
            tz_reg <= negdot(tw_reg[0], tw_reg[1], tw_reg[2]);
        end
    end

    // ------------------------------------------------------------------
    // Output serializer: holds one finished item and sends its nine columns.
    // ------------------------------------------------------------------
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            ser_busy_reg <= 1'b0;
            beat_reg     <= '0;
        end else if (adv && t2_v_reg) begin
            ser_busy_reg <= 1'b1;
            beat_reg     <= '0;
        end else if (out_take) begin
            if (beat_reg == LAST_BEAT) begin
                ser_busy_reg <= 1'b0;
            end
            beat_reg <= beat_reg + 4'd1;
        end
    end

    always_ff @(posedge aclk) begin
        if (adv && t2_v_reg) begin
            o_s2_reg <= t2_s2_reg;
            o_tx_reg <= tx_reg;
            o_ty_reg <= ty_reg;
            o_tz_reg <= tz_reg;
            for (int i = 0; i < 3; i++) begin
                o_u_reg[i] <= t2_u_reg[i];
                o_v_reg[i] <= t2_v_row_reg[i];
                o_w_reg[i] <= t2_w_reg[i];
            end
        end
    end

    always_comb begin
        mat_id  = MAT_VIEW;
        col_idx = 2'd0;
        e0      = '0;
        e1      = '0;
        e2      = '0;
        e3      = '0;
        unique case (beat_reg) inside
            [4'd0:4'd2]: begin
                col_idx = beat_reg[1:0];
                e0      = COORD_W'(o_u_reg[beat_reg[1:0]]);
                e1      = COORD_W'(o_v_reg[beat_reg[1:0]]);
                e2      = COORD_W'(o_w_reg[beat_reg[1:0]]);
            end
            4'd3: begin
                col_idx = 2'd3;
                e0      = o_tx_reg;
                e1      = o_ty_reg;
                e2      = o_tz_reg;
                e3      = ONE_Q16;
            end
            4'd4: begin
                mat_id = MAT_PROJ;
                e0     = p00_reg;
            end
            4'd5: begin
                mat_id  = MAT_PROJ;
                col_idx = 2'd1;
                e1      = -COT_Q16;
            end
            4'd6: begin
                mat_id  = MAT_PROJ;
                col_idx = 2'd2;
                e2      = P22_Q16;
                e3      = ONE_Q16;
            end
            4'd7: begin
                mat_id  = MAT_PROJ;
                col_idx = 2'd3;
                e2      = P32_Q16;
            end
            LAST_BEAT: begin
                mat_id = MAT_FWD;
                e0     = COORD_W'(o_w_reg[0]);
                e1     = COORD_W'(o_s2_reg);
                e2     = -COORD_W'(o_w_reg[2]);
            end
            default: ;
        endcase
    end

    assign m_tvalid = ser_busy_reg;
    assign m_tdata  = {e3, e2, e1, e0};
    assign m_tuser  = {col_idx, mat_id};
    assign m_tlast  = (beat_reg == LAST_BEAT);

endmodule

// File: verif/camera_view_projection_matrix_tb.sv
// Self-checking testbench for camera_view_projection_matrix.
// Depends on cvp_pkg and the block's RTL; it holds its own fixed-point predictor
// and needs no files or arguments.
`timescale 1ns / 100ps

module camera_view_projection_matrix_tb;
    import cvp_pkg::*;

    // Result kinds carried in m_tuser[1:0].
    localparam logic [1:0] MAT_VIEW = 2'd0;
    localparam logic [1:0] MAT_PROJ = 2'd1;
    localparam logic [1:0] MAT_FWD  = 2'd2;

    // Register indexes on the cfg_ port.
    localparam logic REG_WIDTH  = 1'b0;
    localparam logic REG_HEIGHT = 1'b1;

    // Fixed-point constants of the camera math (Q29 angles, Q16.16 results).
    localparam longint PI_Q29      = 64'sd1686629713;
    localparam longint HALF_PI_Q29 = 64'sd843314856;
    localparam longint TWO_PI_Q29  = 64'sd3373259426;
    localparam longint GAIN_Q29    = 64'sd326016437;
    localparam longint unsigned COT_Q32_TB = 64'd10368968296;
    localparam longint COT_Q16   = 64'sd158218;
    localparam longint DEPTH_A   = 64'sd65602;
    localparam longint DEPTH_B   = -64'sd6560;
    localparam longint ONE_Q16   = 64'sd65536;
    // Entry [0][0] for the 1280 x 720 viewport that reset selects.
    localparam longint P00_AT_RESET = 64'sd88998;
    localparam int N_ROWS = 16;

    localparam longint ARCTAN_Q29 [30] = '{
        421657428, 248918915, 131521918, 66762579, 33510843, 16771758,
        8387925, 4194219, 2097141, 1048575, 524288, 262144, 131072, 65536,
        32768, 16384, 8192, 4096, 2048, 1024, 512, 256, 128, 64, 32, 16, 8,
        4, 2, 1
    };

    typedef struct {
        logic signed [15:0] pitch;
        logic signed [15:0] yaw;
        logic signed [15:0] roll;
        logic signed [31:0] px;
        logic signed [31:0] py;
        logic signed [31:0] pz;
        bit                 typed_p00;   // projection [0][0] typed in below
    } camera_pose_t;

    typedef struct packed {
        logic [1:0]       id;
        logic [1:0]       col;
        logic [3:0][31:0] elem;
        logic             last;
    } matrix_column_t;

    logic           aclk;
    logic           aresetn;
    logic           s_tvalid;
    logic           s_tready;
    logic [143:0]   s_tdata;
    logic           m_tvalid;
    logic           m_tready;
    logic [127:0]   m_tdata;
    logic [3:0]     m_tuser;
    logic           m_tlast;
    logic           cfg_wr_en;
    logic           cfg_index;
    logic [VP_W-1:0] cfg_wr_data;

    camera_view_projection_matrix dut (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .s_tvalid    (s_tvalid),
        .s_tready    (s_tready),
        .s_tdata     (s_tdata),
        .m_tvalid    (m_tvalid),
        .m_tready    (m_tready),
        .m_tdata     (m_tdata),
        .m_tuser     (m_tuser),
        .m_tlast     (m_tlast),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_index   (cfg_index),
        .cfg_wr_data (cfg_wr_data)
    );

    // Testbench copy of the two viewport registers.
    longint unsigned vp_width;
    longint unsigned vp_height;

    matrix_column_t pending_columns[$];
    int  mismatches;
    int  columns_seen;
    int  poses_sent;
    int  config_writes;
    bit  gaps_on;
    bit  stim_done;
    int  stall_left;

    initial begin
        aclk = 1'b0;
        forever #5 aclk = ~aclk;
    end

    initial begin
        #2000000;
        $display("Simulation FAILED");
        $finish;
    end

    function automatic longint sat32(input longint v);
        if (v > 64'sd2147483647) return 64'sd2147483647;
        if (v < -64'sd2147483648) return -64'sd2147483648;
        return v;
    endfunction

    function automatic longint qmul(input longint a, input longint b);
        return (a * b + 32768) >>> 16;
    endfunction

    // Exact product of a Q16.16 factor and a full-range position, rounded half up.
    function automatic longint pos_mul(input longint u, input longint p);
        longint ph, pl;
        ph = p >>> 16;
        pl = p - ph * 65536;
        return u * ph + ((u * pl + 32768) >>> 16);
    endfunction

    // Sine and cosine of a Q4.12 angle by range reduction and a 30-step CORDIC.
    task automatic sin_cos(input logic signed [15:0] ang, output longint s,
                           output longint c);
        longint a, x, y, z, nx;
        bit flip;
        a = longint'(ang) * 131072;
        a = a % TWO_PI_Q29;
        flip = 1'b0;
        if (a > PI_Q29) a -= TWO_PI_Q29;
        else if (a < -PI_Q29) a += TWO_PI_Q29;
        if (a > HALF_PI_Q29) begin
            a = PI_Q29 - a;
            flip = 1'b1;
        end else if (a < -HALF_PI_Q29) begin
            a = -PI_Q29 - a;
            flip = 1'b1;
        end
        x = GAIN_Q29;
        y = 0;
        z = a;
        for (int i = 0; i < 30; i++) begin
            if (z >= 0) begin
                nx = x - (y >>> i);
                y  = y + (x >>> i);
                z -= ARCTAN_Q29[i];
            end else begin
                nx = x + (y >>> i);
                y  = y - (x >>> i);
                z += ARCTAN_Q29[i];
            end
            x = nx;
        end
        x = (x + 4096) >>> 13;
        y = (y + 4096) >>> 13;
        s = y;
        c = flip ? -x : x;
    endtask

    function automatic matrix_column_t make_col(input logic [1:0] id, input int col,
                                                input longint e0, input longint e1,
                                                input longint e2, input longint e3,
                                                input bit last);
        matrix_column_t r;
        r.id = id;
        r.col = col[1:0];
        r.elem[0] = 32'(sat32(e0));
        r.elem[1] = 32'(sat32(e1));
        r.elem[2] = 32'(sat32(e2));
        r.elem[3] = 32'(sat32(e3));
        r.last = last;
        return r;
    endfunction

    function automatic longint neg_dot(input longint r[3], input longint p[3]);
        return sat32(-(pos_mul(r[0], p[0]) + pos_mul(r[1], p[1]) + pos_mul(r[2], p[2])));
    endfunction

    // Queue the nine columns that one accepted camera pose must produce.
    task automatic predict_camera_columns(input camera_pose_t pose);
        longint sp, cp, sy, cy, sr, cr, p00;
        longint u[3], v[3], w[3], p[3];
        longint unsigned wd, ht, den;
        sin_cos(pose.pitch, sp, cp);
        sin_cos(pose.yaw, sy, cy);
        sin_cos(pose.roll, sr, cr);
        p[0] = longint'(pose.px);
        p[1] = longint'(pose.py);
        p[2] = longint'(pose.pz);
        // YXZ rotation: yaw about y, pitch about x, roll about z.
        u[0] = sat32(qmul(cy, cr) + qmul(qmul(sy, sp), sr));
        u[1] = sat32(qmul(cp, sr));
        u[2] = sat32(qmul(qmul(cy, sp), sr) - qmul(cr, sy));
        v[0] = sat32(qmul(qmul(cr, sy), sp) - qmul(cy, sr));
        v[1] = sat32(qmul(cp, cr));
        v[2] = sat32(qmul(qmul(cy, cr), sp) + qmul(sy, sr));
        w[0] = sat32(qmul(cp, sy));
        w[1] = sat32(-sp);
        w[2] = sat32(qmul(cy, cp));
        for (int c = 0; c < 3; c++)
            pending_columns.push_back(make_col(MAT_VIEW, c, u[c], v[c], w[c], 0, 0));
        pending_columns.push_back(make_col(MAT_VIEW, 3, neg_dot(u, p), neg_dot(v, p),
                                           neg_dot(w, p), ONE_Q16, 0));
        // A zero viewport register acts as one pixel.
        wd = (vp_width == 0) ? 1 : vp_width;
        ht = (vp_height == 0) ? 1 : vp_height;
        den = wd * 65536;
        p00 = longint'((COT_Q32_TB * ht + den / 2) / den);
        if (pose.typed_p00) p00 = P00_AT_RESET;
        pending_columns.push_back(make_col(MAT_PROJ, 0, p00, 0, 0, 0, 0));
        pending_columns.push_back(make_col(MAT_PROJ, 1, 0, -COT_Q16, 0, 0, 0));
        pending_columns.push_back(make_col(MAT_PROJ, 2, 0, 0, DEPTH_A, ONE_Q16, 0));
        pending_columns.push_back(make_col(MAT_PROJ, 3, 0, 0, DEPTH_B, 0, 0));
        pending_columns.push_back(make_col(MAT_FWD, 0, w[0], sp, -qmul(cp, cy), 0, 1));
    endtask

    // Offer one pose on the s_ channel; s_tvalid stays high after acceptance so
    // back-to-back poses need no low pulse.
    task automatic send_pose(input camera_pose_t pose);
        if (gaps_on && $urandom_range(0, 3) == 0) begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 7)) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {pose.pz, pose.py, pose.px, pose.roll, pose.yaw, pose.pitch};
        do @(posedge aclk); while (!s_tready);
        predict_camera_columns(pose);
        poses_sent++;
    endtask

    function automatic camera_pose_t random_pose();
        camera_pose_t r;
        // Mostly ordinary camera angles, sometimes the full Q4.12 range.
        if ($urandom_range(0, 2) == 0) begin
            r.pitch = 16'($urandom);
            r.yaw   = 16'($urandom);
            r.roll  = 16'($urandom);
        end else begin
            r.pitch = 16'($signed($urandom_range(0, 25736)) - 12868);
            r.yaw   = 16'($signed($urandom_range(0, 25736)) - 12868);
            r.roll  = 16'($signed($urandom_range(0, 25736)) - 12868);
        end
        // Positions: full range now and then, to reach translation saturation.
        if ($urandom_range(0, 3) == 0) begin
            r.px = $urandom;
            r.py = $urandom;
            r.pz = $urandom;
        end else begin
            r.px = 32'($signed($urandom_range(0, 32'h00FF_FFFF)) - 32'sh0080_0000);
            r.py = 32'($signed($urandom_range(0, 32'h00FF_FFFF)) - 32'sh0080_0000);
            r.pz = 32'($signed($urandom_range(0, 32'h00FF_FFFF)) - 32'sh0080_0000);
        end
        r.typed_p00 = 1'b0;
        return r;
    endfunction

    // Wait until every queued column has come back, plus the pipeline depth, so
    // the block is idle before a register write.
    task automatic drain();
        while (pending_columns.size() != 0) @(posedge aclk);
        repeat (60) @(posedge aclk);
    endtask

    task automatic write_reg(input logic idx, input logic [VP_W-1:0] val);
        cfg_wr_en   <= 1'b1;
        cfg_index   <= idx;
        cfg_wr_data <= val;
        @(posedge aclk);
        cfg_wr_en <= 1'b0;
        @(posedge aclk);
        if (idx == REG_WIDTH) vp_width = 64'(val);
        else vp_height = 64'(val);
        config_writes++;
    endtask

    // Result side: check each accepted column, then pick the next m_tready.
    initial begin
        matrix_column_t got, want;
        m_tready = 1'b0;
        stall_left = 0;
        forever begin
            @(posedge aclk);
            if (aresetn && m_tvalid && m_tready) begin
                got.elem = m_tdata;
                got.id   = m_tuser[1:0];
                got.col  = m_tuser[3:2];
                got.last = m_tlast;
                columns_seen++;
                if (pending_columns.size() == 0) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("ERROR: unexpected column id=%0d col=%0d", got.id, got.col);
                end else begin
                    want = pending_columns.pop_front();
                    if (got !== want) begin
                        mismatches++;
                        if (mismatches <= 10)
                            $display({"ERROR: column %0d id/col/last exp %0d/%0d/%0d got ",
                                      "%0d/%0d/%0d, elems exp %h got %h"},
                                     columns_seen, want.id, want.col, want.last,
                                     got.id, got.col, got.last, want.elem, got.elem);
                    end
                end
            end
            if (stall_left > 0) begin
                stall_left--;
                m_tready <= 1'b0;
            end else if (gaps_on && $urandom_range(0, 4) == 0) begin
                stall_left = $urandom_range(0, 6);
                m_tready <= 1'b0;
            end else begin
                m_tready <= 1'b1;
            end
        end
    end

    initial begin
        camera_pose_t rows [N_ROWS];
        logic [VP_W-1:0] widths  [7] = '{1, 32767, 1, 0, 16384, 1920, 640};
        logic [VP_W-1:0] heights [7] = '{1, 1, 32767, 0, 16384, 1080, 480};

        // Directed poses: zero, quarter and half turns, the angle extremes that
        // need reduction, and positions that saturate the translation column.
        rows = '{
            '{16'sd0,      16'sd0,      16'sd0,      32'sd0,  32'sd0,  32'sd0,  1},
            '{16'sd32767,  16'sd32767,  16'sd32767,  32'sd0,  32'sd0,  32'sd0,  1},
            '{-16'sd32768, -16'sd32768, -16'sd32768, 32'sd0,  32'sd0,  32'sd0,  1},
            '{16'sd6434,   16'sd0,      16'sd0,      32'sd65536, 32'sd0, 32'sd0, 1},
            '{-16'sd6434,  16'sd6434,   16'sd0,      32'sd0, 32'sd65536, 32'sd0, 1},
            '{16'sd0,      16'sd12868,  -16'sd12868, 32'sd0, 32'sd0, 32'sd65536, 1},
            '{16'sd12869,  -16'sd12869, 16'sd6433,   32'sd0,  32'sd0,  32'sd0,  1},
            '{16'sd25736,  -16'sd25736, 16'sd25737,  32'sd0,  32'sd0,  32'sd0,  1},
            '{16'sd0, 16'sd0, 16'sd0, 32'sh7FFF_FFFF, 32'sh7FFF_FFFF, 32'sh7FFF_FFFF, 1},
            '{16'sd0, 16'sd0, 16'sd0, -32'sh8000_0000, -32'sh8000_0000,
              -32'sh8000_0000, 1},
            '{16'sd3217, 16'sd3217, 16'sd3217, 32'sh7FFF_FFFF, 32'sh7FFF_FFFF,
              32'sh7FFF_FFFF, 1},
            '{-16'sd3217, 16'sd9651, 16'sd3217, -32'sh8000_0000, 32'sh7FFF_FFFF,
              -32'sh8000_0000, 1},
            '{16'sd1, -16'sd1, 16'sd1, -32'sd1, 32'sd1, -32'sd1, 1},
            '{16'sh5555, 16'shAAAA, 16'sh5555, 32'sh5555_5555, 32'shAAAA_AAAA,
              32'sh5555_5555, 1},
            '{16'shAAAA, 16'sh5555, 16'shAAAA, 32'shAAAA_AAAA, 32'sh5555_5555,
              32'shAAAA_AAAA, 1},
            '{16'sd1000, -16'sd2000, 16'sd3000, 32'sh0001_8000, -32'sh0003_4000,
              32'sh0010_0000, 1}
        };

        mismatches = 0;
        columns_seen = 0;
        poses_sent = 0;
        config_writes = 0;
        gaps_on = 1'b1;
        stim_done = 1'b0;
        aresetn = 1'b0;
        s_tvalid = 1'b0;
        s_tdata = '0;
        cfg_wr_en = 1'b0;
        cfg_index = REG_WIDTH;
        cfg_wr_data = '0;
        vp_width = 1280;
        vp_height = 720;

        repeat (4) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        for (int i = 0; i < N_ROWS; i++) send_pose(rows[i]);
        for (int i = 0; i < 10; i++) send_pose(random_pose());

        // Each further phase sets a new viewport, extremes first, then sends
        // random poses; the last phase runs with no gaps or stalls.
        for (int ph = 0; ph < 8; ph++) begin
            s_tvalid <= 1'b0;
            drain();
            if (ph < 7) begin
                write_reg(REG_WIDTH, widths[ph]);
                write_reg(REG_HEIGHT, heights[ph]);
            end else begin
                write_reg(REG_WIDTH, VP_W'($urandom_range(1, 16384)));
                write_reg(REG_HEIGHT, VP_W'($urandom_range(1, 16384)));
                gaps_on = 1'b0;
            end
            for (int i = 0; i < 32; i++) send_pose(random_pose());
        end
        s_tvalid <= 1'b0;
        stim_done = 1'b1;

        drain();
        $display("Covered %0d camera poses and %0d result columns across %0d register writes,",
                 poses_sent, columns_seen, config_writes);
        $display("including zero and full-range viewports and saturating positions.");
        if (mismatches == 0) begin
            $display("Simulation PASSED");
        end else begin
            $display("%0d mismatching columns", mismatches);
            $display("Simulation FAILED");
        end
        $finish;
    end

endmodule
